>>> hdl/bdtp_pkg.sv
`default_nettype none
package bdtp_pkg;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SEP  = 8'h54;

  // Character positions; POS_DONE marks a finished string.
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_LAST = 4'd14;
  localparam logic [POS_W-1:0] POS_DONE = 4'd15;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [6:0] MONTH_FEB  = 7'd2;
  localparam logic [4:0] FEB_LEAP   = 5'd29;
  localparam logic [4:0] FEB_NORM   = 5'd28;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd0, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    OP_STEP,
    OP_FAIL,
    OP_REARM
  } op_t;

  typedef enum logic [2:0] {
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_SEP,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND
  } fld_t;

  typedef struct packed {
    op_t        op;
    fld_t       fsel;
    logic [3:0] digit;
    logic       bad;
    logic       last;
  } cmd_t;

  // Length of a month; zero for a month number outside the year.
  function automatic logic [4:0] month_days(input logic [1:0] year_low,
                                            input logic [6:0] month);
    logic [3:0] idx;
    idx = month[3:0] - 4'd1;
    if (month == MONTH_FEB) begin
      month_days = (year_low == 2'd0) ? FEB_LEAP : FEB_NORM;
    end else if (month >= 7'd1 && month <= MONTH_MAX) begin
      month_days = MONTH_LEN[idx];
    end else begin
      month_days = 5'd0;
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/bdtp_ifs.sv
`default_nettype none
interface bdtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface bdtp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;

  modport source (output valid, output ok, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink (input valid, input ok, input year, input month, input day,
                input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

>>> hdl/bdtp_front.sv
`default_nettype none
module bdtp_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bdtp_in_if.sink              in_chan,
  input  wire logic            q_ready,
  output bdtp_pkg::cmd_t       q_cmd,
  output logic                 q_push
);
  import bdtp_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             accept;
  logic             is_nul;
  logic             is_digit;
  fld_t             fsel;

  assign in_chan.ready = q_ready;
  assign accept        = in_chan.valid && q_ready;
  assign is_nul        = (in_chan.ch == CH_NUL);
  assign is_digit      = (in_chan.ch >= CH_ZERO) && (in_chan.ch <= CH_NINE);

  always_comb begin
    if (pos_r < 4'd4) begin
      fsel = FLD_YEAR;
    end else if (pos_r < 4'd6) begin
      fsel = FLD_MONTH;
    end else if (pos_r < 4'd8) begin
      fsel = FLD_DAY;
    end else if (pos_r == 4'd8) begin
      fsel = FLD_SEP;
    end else if (pos_r < 4'd11) begin
      fsel = FLD_HOUR;
    end else if (pos_r < 4'd13) begin
      fsel = FLD_MINUTE;
    end else begin
      fsel = FLD_SECOND;
    end
  end

  always_comb begin
    q_cmd.fsel  = fsel;
    q_cmd.digit = 4'(in_chan.ch - CH_ZERO);
    q_cmd.last  = (pos_r == POS_LAST);
    q_cmd.bad   = (fsel == FLD_SEP) ? (in_chan.ch != CH_SEP) : !is_digit;
    q_push      = 1'b0;
    pos_nxt     = pos_r;
    if (is_nul) begin
      q_cmd.op = (pos_r == POS_DONE) ? OP_REARM : OP_FAIL;
      q_push   = accept;
      pos_nxt  = '0;
    end else begin
      q_cmd.op = OP_STEP;
      // Characters after a finished string are dropped here.
      if (pos_r != POS_DONE) begin
        q_push  = accept;
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bdtp_queue.sv
`default_nettype none
module bdtp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bdtp_pkg::cmd_t  push_cmd,
  output logic                 push_ready,
  input  wire logic            pop,
  output bdtp_pkg::cmd_t       pop_cmd,
  output logic                 pop_valid
);
  import bdtp_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    next_ptr = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/bdtp_back.sv
`default_nettype none
module bdtp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bdtp_pkg::cmd_t  cmd,
  input  wire logic            cmd_valid,
  output logic                 cmd_pop,
  bdtp_out_if.source           out_chan
);
  import bdtp_pkg::*;

  logic        err_r, err_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;

  logic        out_valid_r;
  logic        out_ok_r;
  logic [13:0] out_year_r;
  logic [6:0]  out_month_r, out_day_r, out_hour_r, out_minute_r, out_second_r;

  logic [17:0] year_mac;
  logic [6:0]  fld_cur;
  logic [10:0] fld_mac;
  logic [6:0]  fld_new;
  logic        emit;
  logic        emit_ok;
  logic        fields_ok;
  logic [4:0]  dmax;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    unique case (cmd.fsel)
      FLD_MONTH:  fld_cur = month_r;
      FLD_DAY:    fld_cur = day_r;
      FLD_HOUR:   fld_cur = hour_r;
      FLD_MINUTE: fld_cur = minute_r;
      FLD_SECOND: fld_cur = second_r;
      default:    fld_cur = '0;
    endcase
  end

  assign year_mac = 18'(year_r) * 18'd10 + 18'(cmd.digit);
  assign fld_mac  = 11'(fld_cur) * 11'd10 + 11'(cmd.digit);
  assign fld_new  = fld_mac[6:0];

  always_comb begin
    err_nxt    = err_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    unique case (cmd.op)
      OP_STEP: begin
        if (cmd.bad) begin
          err_nxt = 1'b1;
        end else begin
          unique case (cmd.fsel)
            FLD_YEAR:   year_nxt   = year_mac[13:0];
            FLD_MONTH:  month_nxt  = fld_new;
            FLD_DAY:    day_nxt    = fld_new;
            FLD_HOUR:   hour_nxt   = fld_new;
            FLD_MINUTE: minute_nxt = fld_new;
            FLD_SECOND: second_nxt = fld_new;
            default:    err_nxt    = err_r;
          endcase
        end
      end
      OP_FAIL, OP_REARM: begin
        err_nxt    = 1'b0;
        year_nxt   = '0;
        month_nxt  = '0;
        day_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
        second_nxt = '0;
      end
      default: err_nxt = err_r;
    endcase
  end

  // Range checks run on the values that include the final character.
  assign dmax      = month_days(year_nxt[1:0], month_nxt);
  assign fields_ok = (month_nxt >= 7'd1) && (month_nxt <= MONTH_MAX) &&
                     (day_nxt >= 7'd1) && (day_nxt <= 7'(dmax)) &&
                     (hour_nxt <= HOUR_MAX) && (minute_nxt <= MINSEC_MAX) &&
                     (second_nxt <= MINSEC_MAX);
  assign emit      = (cmd.op == OP_FAIL) || ((cmd.op == OP_STEP) && cmd.last);
  assign emit_ok   = (cmd.op == OP_STEP) && !err_nxt && fields_ok;

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      out_ok_r     <= emit_ok;
      // A failed string reports the fields as they stood before the terminator.
      out_year_r   <= (cmd.op == OP_FAIL) ? year_r : year_nxt;
      out_month_r  <= (cmd.op == OP_FAIL) ? month_r : month_nxt;
      out_day_r    <= (cmd.op == OP_FAIL) ? day_r : day_nxt;
      out_hour_r   <= (cmd.op == OP_FAIL) ? hour_r : hour_nxt;
      out_minute_r <= (cmd.op == OP_FAIL) ? minute_r : minute_nxt;
      out_second_r <= (cmd.op == OP_FAIL) ? second_r : second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
    end else begin
      if (cmd_pop) begin
        err_r    <= err_nxt;
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
      end
      if (cmd_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.ok     = out_ok_r;
  assign out_chan.year   = out_year_r;
  assign out_chan.month  = out_month_r;
  assign out_chan.day    = out_day_r;
  assign out_chan.hour   = out_hour_r;
  assign out_chan.minute = out_minute_r;
  assign out_chan.second = out_second_r;

endmodule
`default_nettype wire

>>> hdl/basic_datetime_text_parser_core.sv
// Character-serial parser for date and time text of the form YYYYMMDDTHHMMSS.
// The block takes one character beat per cycle, sustained, as long as results
// are taken; the one decimal multiply-add per character in the execute stage
// sets that figure. A result is registered as its last beat leaves the queue:
// the fifteenth character (ok tells whether the text and the date and time
// are valid, with February 29 allowed in years divisible by four) or a zero
// character that ends the text early (ok low, fields not reached read zero).
// After a completed string characters are dropped until a zero rearms the
// parser; that zero gives no result. A two-entry queue separates the character
// classifier from the execute stage so each side can stall on its own.
`default_nettype none
module basic_datetime_text_parser_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bdtp_in_if.sink    in_chan,
  bdtp_out_if.source out_chan
);
  import bdtp_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic push_ready;
  logic pop;
  logic pop_valid;

  bdtp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_ready (push_ready),
    .q_cmd   (push_cmd),
    .q_push  (push)
  );

  bdtp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  bdtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

>>> verif/basic_datetime_text_parser_core_tb.sv
`default_nettype none
module basic_datetime_text_parser_core_tb;
  import bdtp_pkg::*;

  localparam int unsigned RANDOM_CHARS   = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 24;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } dt_result_t;

  // One character beat of stimulus. A typed row carries its expected outcome directly.
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    bit         has_res;
    dt_result_t res;
  } char_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bdtp_in_if  in_chan ();
  bdtp_out_if out_chan ();

  basic_datetime_text_parser_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  char_row_t  text_rows [$];
  dt_result_t pending_dt [$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Parser state mirrored by the predictor.
  logic [4:0]  pr_pos;
  logic        pr_err;
  logic [13:0] pr_year;
  logic [6:0]  pr_month;
  logic [6:0]  pr_day;
  logic [6:0]  pr_hour;
  logic [6:0]  pr_minute;
  logic [6:0]  pr_second;

  function automatic void rearm_parser();
    pr_pos    = '0;
    pr_err    = 1'b0;
    pr_year   = '0;
    pr_month  = '0;
    pr_day    = '0;
    pr_hour   = '0;
    pr_minute = '0;
    pr_second = '0;
  endfunction

  function automatic bit date_time_ok();
    logic [6:0] last_day;
    case (pr_month)
      7'd2:                         last_day = (pr_year[1:0] == 2'd0) ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:      last_day = 7'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8,
      7'd10, 7'd12:                 last_day = 7'd31;
      default:                      last_day = 7'd0;
    endcase
    return (pr_day >= 7'd1) && (pr_day <= last_day) && (pr_hour <= HOUR_MAX) &&
           (pr_minute <= MINSEC_MAX) && (pr_second <= MINSEC_MAX);
  endfunction

  // Advances the mirrored parser by one character; returns 1 when a result is due.
  function automatic bit parse_char(input logic [7:0] c, output dt_result_t r);
    logic [4:0] p;
    logic [3:0] d;
    bit         fire;
    bit         ok_bit;
    p = pr_pos;
    d = 4'(c - CH_ZERO);
    fire = 1'b0;
    ok_bit = 1'b0;
    if (c == CH_NUL) begin
      fire = (p < POS_DONE);
    end else if (p < POS_DONE) begin
      if (p == 5'd8) begin
        if (c != CH_SEP) pr_err = 1'b1;
      end else if (c < CH_ZERO || c > CH_NINE) begin
        pr_err = 1'b1;
      end else if (p < 5'd4) begin
        pr_year = 14'(pr_year * 10 + d);
      end else if (p < 5'd6) begin
        pr_month = 7'(pr_month * 10 + d);
      end else if (p < 5'd8) begin
        pr_day = 7'(pr_day * 10 + d);
      end else if (p < 5'd11) begin
        pr_hour = 7'(pr_hour * 10 + d);
      end else if (p < 5'd13) begin
        pr_minute = 7'(pr_minute * 10 + d);
      end else begin
        pr_second = 7'(pr_second * 10 + d);
      end
      pr_pos = p + 5'd1;
      fire = (pr_pos == POS_DONE);
      ok_bit = !pr_err && (pr_month >= 7'd1) && (pr_month <= MONTH_MAX) && date_time_ok();
    end
    r = '{ok_bit, pr_year, pr_month, pr_day, pr_hour, pr_minute, pr_second};
    if (c == CH_NUL) rearm_parser();
    return fire;
  endfunction

  task automatic push_row(input logic [7:0] c, input bit typed, input bit has_res,
                          input dt_result_t res);
    char_row_t row;
    row.ch = c;
    row.typed = typed;
    row.has_res = has_res;
    row.res = res;
    text_rows.push_back(row);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_row(s[i], 1'b0, 1'b0, '0);
  endtask

  function automatic logic [7:0] digit_of(input int unsigned v, input int unsigned scale);
    return CH_ZERO + 8'((v / scale) % 10);
  endfunction

  // One random string: mostly well-formed dates with random contents, some
  // corrupted, cut short, or plain noise. Every string ends rearmed.
  task automatic gen_text();
    logic [7:0]  txt [15];
    int unsigned mode, yr, mo, dy, hr, mi, se, cut;
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      repeat ($urandom_range(1, 20)) push_row(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      push_row(CH_NUL, 1'b0, 1'b0, '0);
    end else begin
      yr = $urandom_range(0, 9999);
      mo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       dy = $urandom_range(0, 99);
        1:       dy = $urandom_range(27, 32);
        default: dy = $urandom_range(1, 31);
      endcase
      hr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 24);
      mi = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
      se = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
      txt[0]  = digit_of(yr, 1000);
      txt[1]  = digit_of(yr, 100);
      txt[2]  = digit_of(yr, 10);
      txt[3]  = digit_of(yr, 1);
      txt[4]  = digit_of(mo, 10);
      txt[5]  = digit_of(mo, 1);
      txt[6]  = digit_of(dy, 10);
      txt[7]  = digit_of(dy, 1);
      txt[8]  = CH_SEP;
      txt[9]  = digit_of(hr, 10);
      txt[10] = digit_of(hr, 1);
      txt[11] = digit_of(mi, 10);
      txt[12] = digit_of(mi, 1);
      txt[13] = digit_of(se, 10);
      txt[14] = digit_of(se, 1);
      if (mode == 7) txt[$urandom_range(0, 14)] = 8'($urandom_range(1, 255));
      cut = (mode == 8) ? $urandom_range(0, 14) : 15;
      for (int i = 0; i < cut; i++) push_row(txt[i], 1'b0, 1'b0, '0);
      if (cut == 15) begin
        // Characters after a completed string are dropped until the zero.
        repeat ($urandom_range(0, 2)) push_row(8'($urandom_range(1, 255)), 1'b0, 1'b0, '0);
      end
      push_row(CH_NUL, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic check_result(input dt_result_t got);
    dt_result_t want;
    if (pending_dt.size() == 0) begin
      $error("result without a pending expectation: %p", got);
      mismatch_cnt++;
    end else begin
      want = pending_dt.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        mismatch_cnt++;
      end
      if (got.year !== want.year) begin
        $error("year: expected %0d, got %0d", want.year, got.year);
        mismatch_cnt++;
      end
      if (got.month !== want.month) begin
        $error("month: expected %0d, got %0d", want.month, got.month);
        mismatch_cnt++;
      end
      if (got.day !== want.day) begin
        $error("day: expected %0d, got %0d", want.day, got.day);
        mismatch_cnt++;
      end
      if (got.hour !== want.hour) begin
        $error("hour: expected %0d, got %0d", want.hour, got.hour);
        mismatch_cnt++;
      end
      if (got.minute !== want.minute) begin
        $error("minute: expected %0d, got %0d", want.minute, got.minute);
        mismatch_cnt++;
      end
      if (got.second !== want.second) begin
        $error("second: expected %0d, got %0d", want.second, got.second);
        mismatch_cnt++;
      end
    end
  endtask

  // Result side: random back-pressure with calm stretches.
  initial begin
    int unsigned stall;
    bit          calm;
    calm = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      check_result('{out_chan.ok, out_chan.year, out_chan.month, out_chan.day,
                     out_chan.hour, out_chan.minute, out_chan.second});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Character side: builds the stimulus, drives it and records expectations.
  initial begin
    char_row_t   row;
    dt_result_t  pred;
    bit          fire;
    bit          calm;
    bit          hold_off;
    int unsigned gap;
    int unsigned n_directed;
    int unsigned mid_point;

    in_chan.valid <= 1'b0;
    in_chan.ch    <= CH_NUL;
    rearm_parser();
    calm = 1'b0;

    // An empty string fails with every field zero.
    push_row(CH_NUL, 1'b1, 1'b1, '0);
    // Largest legal value in every field.
    push_text("99991231T23595");
    push_row("9", 1'b1, 1'b1, '{1'b1, 14'd9999, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59});
    // Dropped after completion, then a silent rearm.
    push_row(8'hFF, 1'b1, 1'b0, '0);
    push_row(CH_NUL, 1'b1, 1'b0, '0);
    // A non-digit leaves the year alone; the early zero reports what was parsed.
    push_text("1");
    push_row(8'hFF, 1'b0, 1'b0, '0);
    push_row(CH_NUL, 1'b1, 1'b1, '{1'b0, 14'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
    n_directed = text_rows.size();
    while (text_rows.size() < n_directed + RANDOM_CHARS) gen_text();
    mid_point = n_directed + (text_rows.size() - n_directed) / 2;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int unsigned i = 0; i < text_rows.size(); i++) begin
      row = text_rows[i];
      hold_off = (i == n_directed) || (i == mid_point);
      if ($urandom_range(0, 40) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (hold_off && gap == 0) gap = 1;
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        if (hold_off) begin
          while (pending_dt.size() != 0) @(posedge clk);
        end
        repeat (gap) @(posedge clk);
      end
      in_chan.valid <= 1'b1;
      in_chan.ch    <= row.ch;
      do @(posedge clk); while (!in_chan.ready);
      fire = parse_char(row.ch, pred);
      if (row.typed) begin
        if (row.has_res) pending_dt.push_back(row.res);
      end else if (fire) begin
        pending_dt.push_back(pred);
      end
    end
    in_chan.valid <= 1'b0;

    while (pending_dt.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hdl/bdtp_pkg.sv
hdl/bdtp_ifs.sv
hdl/bdtp_front.sv
hdl/bdtp_queue.sv
hdl/bdtp_back.sv
hdl/basic_datetime_text_parser_core.sv
verif/basic_datetime_text_parser_core_tb.sv
